// ===== rtl/wwhf_pkg.sv =====
// Shared types, character codes and helper functions for the word wrap formatter.
package wwhf_pkg;

   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned COL_W        = 9;
   localparam int unsigned ESC_POS_W    = 3;
   localparam int unsigned ESC_LEN      = 6;

   localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_PRINT_LO = 8'h21;
   localparam logic [BYTE_W-1:0] CH_PRINT_HI = 8'h7E;
   localparam logic [BYTE_W-1:0] CH_LT      = 8'h3C;
   localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CH_X       = 8'h78;
   localparam logic [BYTE_W-1:0] CH_GT      = 8'h3E;

   localparam logic [ESC_POS_W-1:0] ESC_POS_LT   = 3'd0;
   localparam logic [ESC_POS_W-1:0] ESC_POS_ZERO = 3'd1;
   localparam logic [ESC_POS_W-1:0] ESC_POS_X    = 3'd2;
   localparam logic [ESC_POS_W-1:0] ESC_POS_HI   = 3'd3;
   localparam logic [ESC_POS_W-1:0] ESC_POS_LO   = 3'd4;
   localparam logic [ESC_POS_W-1:0] ESC_POS_GT   = 3'd5;

   localparam logic [COL_W-1:0]  COL_MAX     = 9'd511;
   localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'd72;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ESC,
      ST_BREAK,
      ST_WORD,
      ST_DELIM
   } state_type;

   typedef enum logic [1:0] {
      EMIT_BREAK,
      EMIT_WORD,
      EMIT_DELIM
   } emit_sel_type;

   typedef struct packed {
      logic                 capture;
      logic                 store_char;
      logic                 set_ovf;
      logic                 esc_write;
      logic [ESC_POS_W-1:0] esc_pos;
      logic                 esc_done;
      logic                 rd_first;
      logic                 rd_next;
      logic                 emit;
      emit_sel_type         emit_sel;
      logic                 finish;
   } cmd_type;

   typedef struct packed {
      logic is_delim;
      logic is_print;
      logic word_fits;
      logic esc_fits;
      logic need_break;
      logic len_zero;
      logic more;
      logic slot_free;
   } status_type;

   function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
      logic [BYTE_W-1:0] ch;
      if (nib < 4'd10) begin
         ch = CH_ZERO + {4'd0, nib};
      end else begin
         ch = 8'h37 + {4'd0, nib};
      end
      return ch;
   endfunction

   function automatic logic [BYTE_W-1:0] esc_char(input logic [ESC_POS_W-1:0] pos,
                                                  input logic [BYTE_W-1:0]    raw);
      logic [BYTE_W-1:0] ch;
      case (pos)
         ESC_POS_LT:   ch = CH_LT;
         ESC_POS_ZERO: ch = CH_ZERO;
         ESC_POS_X:    ch = CH_X;
         ESC_POS_HI:   ch = hex_digit(raw[7:4]);
         ESC_POS_LO:   ch = hex_digit(raw[3:0]);
         ESC_POS_GT:   ch = CH_GT;
         default:      ch = CH_GT;
      endcase
      return ch;
   endfunction

endpackage

// ===== rtl/wwhf_channels.sv =====
// Valid/ready channel interfaces for input bytes and formatted output bytes.
interface wwhf_req_if;
   logic                          valid;
   logic                          ready;
   logic [wwhf_pkg::BYTE_W-1:0]   in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface wwhf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wwhf_pkg::BYTE_W-1:0]   out_byte;
   logic                          last;
   logic                          truncated;

   modport source (output valid, output out_byte, output last, output truncated, input ready);
   modport sink   (input valid, input out_byte, input last, input truncated, output ready);
endinterface

// ===== rtl/wwhf_ctrl.sv =====
// Sequencer for byte intake, escape expansion and word emission.
module wwhf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wwhf_pkg::status_type status,
   output wwhf_pkg::cmd_type    cmd
);

   wwhf_pkg::state_type                   state_ff;
   wwhf_pkg::state_type                   state_in;
   logic [wwhf_pkg::ESC_POS_W-1:0]        esc_pos_ff;
   logic [wwhf_pkg::ESC_POS_W-1:0]        esc_pos_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= wwhf_pkg::ST_IDLE;
         esc_pos_ff <= '0;
      end else begin
         state_ff   <= state_in;
         esc_pos_ff <= esc_pos_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      esc_pos_in = esc_pos_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.emit_sel = wwhf_pkg::EMIT_WORD;
      case (state_ff)
         wwhf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (status.is_delim) begin
                  cmd.rd_first = 1'b1;
                  if (status.need_break) begin
                     state_in = wwhf_pkg::ST_BREAK;
                  end else if (status.len_zero) begin
                     state_in = wwhf_pkg::ST_DELIM;
                  end else begin
                     state_in = wwhf_pkg::ST_WORD;
                  end
               end else if (status.is_print) begin
                  if (status.word_fits) begin
                     cmd.store_char = 1'b1;
                  end else begin
                     cmd.set_ovf = 1'b1;
                  end
               end else if (status.esc_fits) begin
                  cmd.esc_write = 1'b1;
                  cmd.esc_pos   = wwhf_pkg::ESC_POS_LT;
                  esc_pos_in    = wwhf_pkg::ESC_POS_ZERO;
                  state_in      = wwhf_pkg::ST_ESC;
               end else begin
                  cmd.set_ovf = 1'b1;
               end
            end
         end
         wwhf_pkg::ST_ESC: begin
            cmd.esc_write = 1'b1;
            cmd.esc_pos   = esc_pos_ff;
            esc_pos_in    = esc_pos_ff + wwhf_pkg::ESC_POS_W'(1);
            if (esc_pos_ff == wwhf_pkg::ESC_POS_GT) begin
               cmd.esc_done = 1'b1;
               state_in     = wwhf_pkg::ST_IDLE;
            end
         end
         wwhf_pkg::ST_BREAK: begin
            if (status.slot_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = wwhf_pkg::EMIT_BREAK;
               state_in     = status.len_zero ? wwhf_pkg::ST_DELIM : wwhf_pkg::ST_WORD;
            end
         end
         wwhf_pkg::ST_WORD: begin
            if (status.slot_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = wwhf_pkg::EMIT_WORD;
               if (status.more) begin
                  cmd.rd_next = 1'b1;
               end else begin
                  state_in = wwhf_pkg::ST_DELIM;
               end
            end
         end
         wwhf_pkg::ST_DELIM: begin
            if (status.slot_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = wwhf_pkg::EMIT_DELIM;
               cmd.finish   = 1'b1;
               state_in     = wwhf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wwhf_pkg::ST_IDLE;
         end
      endcase
   end

   a_delim_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && status.is_delim) |=> !req_ready)
      else $error("intake open right after a delimiter transfer");

   a_finish_reopens: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> req_ready)
      else $error("intake not reopened after the delimiter");

   a_word_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.emit_sel == wwhf_pkg::EMIT_WORD) |-> !status.len_zero)
      else $error("word byte emitted from an empty word");

endmodule

// ===== rtl/wwhf_dp.sv =====
// Word store, length, column and output register of the word wrap formatter.
module wwhf_dp #(
   parameter int unsigned WORD_CHARS = 60
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [wwhf_pkg::BYTE_W-1:0]       csr_wdata,
   input  logic [wwhf_pkg::BYTE_W-1:0]       req_byte,
   input  wwhf_pkg::cmd_type                 cmd,
   output wwhf_pkg::status_type              status,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [wwhf_pkg::BYTE_W-1:0]       rsp_byte,
   output logic                              rsp_last,
   output logic                              rsp_truncated
);

   localparam int unsigned LEN_W  = $clog2(WORD_CHARS + 1);
   localparam int unsigned ADDR_W = $clog2(WORD_CHARS);
   localparam int unsigned SUM_W  = wwhf_pkg::COL_W + 1;

   logic [wwhf_pkg::BYTE_W-1:0] word_mem [WORD_CHARS];

   logic [wwhf_pkg::BYTE_W-1:0] limit_ff;
   logic [wwhf_pkg::BYTE_W-1:0] byte_ff;
   logic [wwhf_pkg::BYTE_W-1:0] rd_data_ff;
   logic [LEN_W-1:0]            len_ff;
   logic [LEN_W-1:0]            len_in;
   logic [LEN_W-1:0]            idx_ff;
   logic [LEN_W-1:0]            idx_in;
   logic [wwhf_pkg::COL_W-1:0]  col_ff;
   logic [wwhf_pkg::COL_W-1:0]  col_in;
   logic                        ovf_ff;
   logic                        ovf_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [wwhf_pkg::BYTE_W-1:0] rsp_byte_ff;
   logic [wwhf_pkg::BYTE_W-1:0] rsp_byte_in;
   logic                        rsp_last_ff;
   logic                        rsp_truncated_ff;

   logic                        mem_we;
   logic [ADDR_W-1:0]           mem_waddr;
   logic [wwhf_pkg::BYTE_W-1:0] mem_wdata;
   logic                        mem_re;
   logic [ADDR_W-1:0]           mem_raddr;
   logic [LEN_W:0]              esc_end;
   logic [LEN_W-1:0]            esc_addr;
   logic [SUM_W-1:0]            col_sum;
   logic [wwhf_pkg::BYTE_W-1:0] delim_byte;

   always_comb begin
      esc_end  = {1'b0, len_ff} + (LEN_W+1)'(wwhf_pkg::ESC_LEN);
      esc_addr = len_ff + LEN_W'(cmd.esc_pos);
      col_sum  = SUM_W'(col_ff) + SUM_W'(len_ff) + SUM_W'(1);
      delim_byte = byte_ff;

      status.is_delim   = (req_byte == wwhf_pkg::CH_SPACE) ||
                          (req_byte == wwhf_pkg::CH_NEWLINE);
      status.is_print   = req_byte inside {[wwhf_pkg::CH_PRINT_LO:wwhf_pkg::CH_PRINT_HI]};
      status.word_fits  = len_ff < LEN_W'(WORD_CHARS);
      status.esc_fits   = esc_end <= (LEN_W+1)'(WORD_CHARS);
      status.need_break = (col_ff != '0) && (col_sum > SUM_W'(limit_ff));
      status.len_zero   = len_ff == '0;
      status.more       = idx_ff < len_ff;
      status.slot_free  = !rsp_valid_ff || rsp_ready;

      mem_we    = cmd.store_char || cmd.esc_write;
      mem_waddr = cmd.store_char ? ADDR_W'(len_ff) : ADDR_W'(esc_addr);
      mem_wdata = cmd.store_char ? req_byte : wwhf_pkg::esc_char(cmd.esc_pos, byte_ff);
      mem_re    = cmd.rd_first || cmd.rd_next;
      mem_raddr = cmd.rd_first ? '0 : ADDR_W'(idx_ff);

      len_in = len_ff;
      if (cmd.store_char) begin
         len_in = len_ff + LEN_W'(1);
      end else if (cmd.esc_done) begin
         len_in = len_ff + LEN_W'(wwhf_pkg::ESC_LEN);
      end else if (cmd.finish) begin
         len_in = '0;
      end

      idx_in = idx_ff;
      if (cmd.rd_first) begin
         idx_in = LEN_W'(1);
      end else if (cmd.rd_next) begin
         idx_in = idx_ff + LEN_W'(1);
      end

      ovf_in = ovf_ff;
      if (cmd.set_ovf) begin
         ovf_in = 1'b1;
      end else if (cmd.finish) begin
         ovf_in = 1'b0;
      end

      col_in = col_ff;
      if (cmd.emit && cmd.emit_sel == wwhf_pkg::EMIT_BREAK) begin
         col_in = '0;
      end else if (cmd.finish) begin
         if (delim_byte == wwhf_pkg::CH_NEWLINE) begin
            col_in = '0;
         end else if (col_sum > SUM_W'(wwhf_pkg::COL_MAX)) begin
            col_in = wwhf_pkg::COL_MAX;
         end else begin
            col_in = col_sum[wwhf_pkg::COL_W-1:0];
         end
      end

      case (cmd.emit_sel)
         wwhf_pkg::EMIT_BREAK: rsp_byte_in = wwhf_pkg::CH_NEWLINE;
         wwhf_pkg::EMIT_WORD:  rsp_byte_in = rd_data_ff;
         wwhf_pkg::EMIT_DELIM: rsp_byte_in = delim_byte;
         default:              rsp_byte_in = rd_data_ff;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         word_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= word_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= wwhf_pkg::LIMIT_RESET;
         len_ff       <= '0;
         col_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         len_ff       <= len_in;
         col_ff       <= col_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.capture) begin
         byte_ff <= req_byte;
      end
      if (cmd.emit) begin
         rsp_byte_ff      <= rsp_byte_in;
         rsp_last_ff      <= cmd.emit_sel == wwhf_pkg::EMIT_DELIM;
         rsp_truncated_ff <= ovf_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_byte      = rsp_byte_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_truncated = rsp_truncated_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(WORD_CHARS))
      else $error("word length beyond the store depth");

endmodule

// ===== rtl/word_wrap_hex_escape_formatter.sv =====
// Word wrap formatter top level: one input byte per transfer, formatted bytes out.
// A printable byte is appended to the pending word. Any other byte but a space or
// newline is stored as a six-character <0xHH> escape, written one character at a time
// by the single write port of the word store. A space or newline is accepted, then
// its bytes (optional line break, the word, the delimiter) go in turn through the
// output register; the next byte is accepted in the cycle after the delimiter is
// handed to the output register. Overflowing bytes are dropped and flag truncated on
// the next emitted word. There is no clearing pass after reset. csr_wdata sets the
// line limit; the user must write it only while the block is idle (not enforced).
module word_wrap_hex_escape_formatter #(
   parameter int unsigned WORD_CHARS = 60
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [wwhf_pkg::BYTE_W-1:0] csr_wdata,
   wwhf_req_if.sink                    req_ch,
   wwhf_rsp_if.source                  rsp_ch
);

   wwhf_pkg::cmd_type    cmd;
   wwhf_pkg::status_type status;

   wwhf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wwhf_dp #(
      .WORD_CHARS (WORD_CHARS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_byte      (req_ch.in_byte),
      .cmd           (cmd),
      .status        (status),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_byte      (rsp_ch.out_byte),
      .rsp_last      (rsp_ch.last),
      .rsp_truncated (rsp_ch.truncated)
   );

endmodule

// ===== tb/tb_word_wrap_hex_escape_formatter.sv =====
// Self-checking testbench for the word wrap formatter with hex escapes.
module tb_word_wrap_hex_escape_formatter;

   localparam int unsigned WORD_CHARS    = 60;
   localparam int unsigned DIR_ROWS      = 24;
   localparam int unsigned NUM_PHASES    = 6;
   localparam int unsigned PHASE_ITEMS   = 48;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam longint     RUN_LIMIT     = 5_000_000;

   typedef struct packed {
      logic [wwhf_pkg::BYTE_W-1:0] out_byte;
      logic                        last;
      logic                        truncated;
   } fmt_char_type;

   typedef struct packed {
      logic [wwhf_pkg::BYTE_W-1:0] in_byte;
      logic                        fixed;
      logic                        emits;
      logic                        trunc;
   } stim_row_type;

   typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_SPARSE} rx_mode_type;

   logic                        clock;
   logic                        reset;
   logic                        csr_we;
   logic [wwhf_pkg::BYTE_W-1:0] csr_wdata;

   wwhf_req_if req_bus();
   wwhf_rsp_if rsp_bus();

   word_wrap_hex_escape_formatter #(
      .WORD_CHARS(WORD_CHARS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .req_ch   (req_bus),
      .rsp_ch   (rsp_bus)
   );

   logic [wwhf_pkg::BYTE_W-1:0] word_buf [WORD_CHARS];
   int unsigned                 word_len;
   logic [wwhf_pkg::COL_W-1:0]  col_count;
   logic                        ovf_seen;
   logic [wwhf_pkg::BYTE_W-1:0] line_limit;

   fmt_char_type      expected_chars [$];
   fmt_char_type      head_char;
   int unsigned       fail_count;
   int unsigned       burst_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [wwhf_pkg::BYTE_W-1:0] nibble_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return 8'h30 + {4'd0, n};
      end
      return 8'h41 + {4'd0, n} - 8'd10;
   endfunction

   function automatic void put_char(input logic [wwhf_pkg::BYTE_W-1:0] ch, input logic last,
                                    input logic trunc, input bit keep);
      fmt_char_type c;
      c.out_byte  = ch;
      c.last      = last;
      c.truncated = trunc;
      if (keep) begin
         expected_chars.push_back(c);
      end
   endfunction

   function automatic void format_byte(input logic [wwhf_pkg::BYTE_W-1:0] b, input bit keep);
      int unsigned need;
      int unsigned sum;
      logic        trunc;
      if (b == wwhf_pkg::CH_SPACE || b == wwhf_pkg::CH_NEWLINE) begin
         trunc = ovf_seen;
         need  = col_count + word_len + 1;
         if (col_count != 0 && need > line_limit) begin
            put_char(wwhf_pkg::CH_NEWLINE, 1'b0, trunc, keep);
            col_count = '0;
         end
         for (int i = 0; i < word_len; i++) begin
            put_char(word_buf[i], 1'b0, trunc, keep);
         end
         put_char(b, 1'b1, trunc, keep);
         sum       = col_count + word_len + 1;
         col_count = (sum > wwhf_pkg::COL_MAX) ? wwhf_pkg::COL_MAX : wwhf_pkg::COL_W'(sum);
         if (b == wwhf_pkg::CH_NEWLINE) begin
            col_count = '0;
         end
         word_len = 0;
         ovf_seen = 1'b0;
      end else if (b >= wwhf_pkg::CH_PRINT_LO && b <= wwhf_pkg::CH_PRINT_HI) begin
         if (word_len < WORD_CHARS) begin
            word_buf[word_len] = b;
            word_len++;
         end else begin
            ovf_seen = 1'b1;
         end
      end else if (word_len + wwhf_pkg::ESC_LEN <= WORD_CHARS) begin
         word_buf[word_len]     = wwhf_pkg::CH_LT;
         word_buf[word_len + 1] = wwhf_pkg::CH_ZERO;
         word_buf[word_len + 2] = wwhf_pkg::CH_X;
         word_buf[word_len + 3] = nibble_char(b[7:4]);
         word_buf[word_len + 4] = nibble_char(b[3:0]);
         word_buf[word_len + 5] = wwhf_pkg::CH_GT;
         word_len += wwhf_pkg::ESC_LEN;
      end else begin
         ovf_seen = 1'b1;
      end
   endfunction

   function automatic logic [wwhf_pkg::BYTE_W-1:0] pick_escape_byte();
      logic [wwhf_pkg::BYTE_W-1:0] r;
      r = wwhf_pkg::BYTE_W'($urandom_range(0, 255));
      while ((r >= wwhf_pkg::CH_PRINT_LO && r <= wwhf_pkg::CH_PRINT_HI) ||
             r == wwhf_pkg::CH_SPACE || r == wwhf_pkg::CH_NEWLINE) begin
         r = wwhf_pkg::BYTE_W'($urandom_range(0, 255));
      end
      return r;
   endfunction

   task automatic send_byte(input logic [wwhf_pkg::BYTE_W-1:0] b, input bit use_model);
      @(negedge clock);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      burst_left--;
      format_byte(b, use_model);
   endtask

   task automatic send_word(input bit long_word, inout int unsigned sent);
      int unsigned len;
      len = long_word ? $urandom_range(52, 70) : $urandom_range(0, 12);
      repeat (len) begin
         if ($urandom_range(0, 5) == 0) begin
            send_byte(pick_escape_byte(), 1'b1);
         end else begin
            send_byte(wwhf_pkg::BYTE_W'($urandom_range(wwhf_pkg::CH_PRINT_LO,
                                                       wwhf_pkg::CH_PRINT_HI)), 1'b1);
         end
      end
      send_byte(($urandom_range(0, 3) == 0) ? wwhf_pkg::CH_NEWLINE : wwhf_pkg::CH_SPACE, 1'b1);
      sent += len + 1;
   endtask

   task automatic drain_expected();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_line_limit(input logic [wwhf_pkg::BYTE_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      line_limit = value;
   endtask

   // receiver: hold ready per pattern, switching between randomly chosen patterns
   initial begin
      rx_mode_type rx_mode;
      int unsigned rx_span;
      int unsigned rx_tick;
      rsp_bus.ready = 1'b0;
      rx_mode       = RX_OPEN;
      rx_span       = 0;
      rx_tick       = 0;
      forever begin
         @(negedge clock);
         if (rx_span == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_span = $urandom_range(16, 96);
         end
         rx_span--;
         rx_tick++;
         case (rx_mode)
            RX_OPEN: begin
               rsp_bus.ready <= 1'b1;
            end
            RX_COIN: begin
               rsp_bus.ready <= 1'($urandom_range(0, 1));
            end
            RX_COMB: begin
               rsp_bus.ready <= (rx_tick % 3 != 0);
            end
            default: begin
               rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual byte %02h last %b trunc %b",
                     $time, rsp_bus.out_byte, rsp_bus.last, rsp_bus.truncated);
            fail_count++;
         end else begin
            head_char = expected_chars.pop_front();
            if (rsp_bus.out_byte !== head_char.out_byte) begin
               $display("%0t: out_byte expected %02h actual %02h",
                        $time, head_char.out_byte, rsp_bus.out_byte);
               fail_count++;
            end
            if (rsp_bus.last !== head_char.last) begin
               $display("%0t: last expected %b actual %b",
                        $time, head_char.last, rsp_bus.last);
               fail_count++;
            end
            if (rsp_bus.truncated !== head_char.truncated) begin
               $display("%0t: truncated expected %b actual %b",
                        $time, head_char.truncated, rsp_bus.truncated);
               fail_count++;
            end
         end
      end
   end

   initial begin
      stim_row_type                dir_rows [DIR_ROWS];
      logic [wwhf_pkg::BYTE_W-1:0] phase_limits [NUM_PHASES];
      fmt_char_type                fixed_char;
      int unsigned                 sent;

      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.in_byte = '0;
      fail_count      = 0;
      burst_left      = 0;
      line_limit      = wwhf_pkg::LIMIT_RESET;
      word_len        = 0;
      col_count       = '0;
      ovf_seen        = 1'b0;

      dir_rows = '{
         '{wwhf_pkg::CH_SPACE,   1'b1, 1'b1, 1'b0},
         '{wwhf_pkg::CH_NEWLINE, 1'b1, 1'b1, 1'b0},
         '{8'h21,                1'b1, 1'b0, 1'b0},
         '{8'h7E,                1'b1, 1'b0, 1'b0},
         '{wwhf_pkg::CH_SPACE,   1'b0, 1'b0, 1'b0},
         '{8'h00,                1'b1, 1'b0, 1'b0},
         '{8'hFF,                1'b1, 1'b0, 1'b0},
         '{wwhf_pkg::CH_NEWLINE, 1'b0, 1'b0, 1'b0},
         '{8'h7F,                1'b1, 1'b0, 1'b0},
         '{8'h80,                1'b1, 1'b0, 1'b0},
         '{8'h1F,                1'b1, 1'b0, 1'b0},
         '{8'h09,                1'b1, 1'b0, 1'b0},
         '{8'h0D,                1'b1, 1'b0, 1'b0},
         '{8'h41,                1'b1, 1'b0, 1'b0},
         '{wwhf_pkg::CH_SPACE,   1'b0, 1'b0, 1'b0},
         '{8'h01,                1'b1, 1'b0, 1'b0},
         '{8'h02,                1'b1, 1'b0, 1'b0},
         '{8'h03,                1'b1, 1'b0, 1'b0},
         '{8'h04,                1'b1, 1'b0, 1'b0},
         '{8'h05,                1'b1, 1'b0, 1'b0},
         '{8'h06,                1'b1, 1'b0, 1'b0},
         '{8'h07,                1'b1, 1'b0, 1'b0},
         '{wwhf_pkg::CH_SPACE,   1'b0, 1'b0, 1'b0},
         '{wwhf_pkg::CH_NEWLINE, 1'b1, 1'b1, 1'b0}
      };
      phase_limits = '{8'd1, 8'd255, 8'd0, 8'd30, 8'd72, 8'd72};
      phase_limits[4] = wwhf_pkg::BYTE_W'($urandom_range(2, 254));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         send_byte(dir_rows[r].in_byte, !dir_rows[r].fixed);
         if (dir_rows[r].fixed && dir_rows[r].emits) begin
            fixed_char.out_byte  = dir_rows[r].in_byte;
            fixed_char.last      = 1'b1;
            fixed_char.truncated = dir_rows[r].trunc;
            expected_chars.push_back(fixed_char);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_expected();
         write_line_limit(phase_limits[p]);
         sent = 0;
         if (p % 2 == 1) begin
            send_word(1'b1, sent);
         end
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
               send_byte(wwhf_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
               sent++;
            end else begin
               send_word($urandom_range(0, 9) == 0, sent);
            end
         end
      end

      drain_expected();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
